### hw/rtl/coordinate_delta_encoder_defines.svh
// ----------------------------------------------------------------------------
// Coordinate delta encoder assertion macros
// Shared concurrent assertion helpers; the user module must have clk, rst_n.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_DELTA_ENCODER_DEFINES_SVH
`define COORDINATE_DELTA_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CDE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cde_pkg.sv
// ----------------------------------------------------------------------------
// Coordinate delta encoder package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
package cde_pkg;

  localparam int COORD_W     = 48;
  localparam int FRAC_BITS   = 24;
  localparam int SCALE_W     = 31;
  localparam int DIMS_W      = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int VALUE_W     = 32;
  localparam int PROD_W      = 55;   // 24-bit half times 31-bit scale
  localparam int SUM_W       = 56;

  localparam int CDE_QUEUE_DEPTH = 4;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 31'd10000000;
  localparam logic [DIMS_W-1:0]  DIMS_RESET  = 3'd2;
  localparam logic [DIMS_W-1:0]  DIMS_MIN    = 3'd2;
  localparam logic [DIMS_W-1:0]  DIMS_MAX    = 3'd4;

  localparam logic [VALUE_W-1:0] EMPTY_VALUE = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] DELTA_POS   = 32'h0000_7FFF;
  localparam logic [VALUE_W-1:0] DELTA_NEG   = 32'hFFFF_8001;
  localparam logic [7:0]         ESC_LO      = 8'h00;
  localparam logic [7:0]         ESC_HI      = 8'h80;
  localparam logic [SUM_W-1:0]   HALF_LSB    = 56'h80_0000;
  localparam logic [SUM_W-1:0]   POS_LIMIT   = 56'h7FFF_FFFF;
  localparam logic [SUM_W-1:0]   NEG_LIMIT   = 56'h8000_0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COORD_SCALE     = 2'd0,
    REG_DIMS_PER_VERTEX = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_ABS4   = 2'd0,   // absolute value, 4 bytes
    KIND_DELTA2 = 2'd1,   // short delta, 2 bytes
    KIND_ESC6   = 2'd2,   // escape code then 4-byte delta
    KIND_ERROR  = 2'd3    // scaling overflow, one error byte
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
  } entry_t;

  function automatic logic [2:0] last_index(kind_t kind);
    logic [2:0] idx;
    case (kind)
      KIND_ABS4:   idx = 3'd3;
      KIND_DELTA2: idx = 3'd1;
      KIND_ESC6:   idx = 3'd5;
      KIND_ERROR:  idx = 3'd0;
      default:     idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

### hw/rtl/cde_front.sv
// ----------------------------------------------------------------------------
// Coordinate delta encoder front end
// Scales each coordinate, classifies it against per-dimension history.
// ----------------------------------------------------------------------------
module cde_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_take,
  input  logic [cde_pkg::COORD_W-1:0]  coord_fixed,
  input  logic                         is_empty,
  input  logic                         starts_sequence,
  input  logic [cde_pkg::SCALE_W-1:0]  cfg_scale,
  input  logic [cde_pkg::DIMS_W-1:0]   cfg_dims,
  output logic                         push,
  output cde_pkg::entry_t              push_entry,
  output logic [1:0]                   inflight
);
  import cde_pkg::*;

  // Stage 1: sign and magnitude split.
  logic                 v1_r, neg1_r, empty1_r, start1_r;
  logic [23:0]          hi1_r, lo1_r;
  // Stage 2: partial products.
  logic                 v2_r, neg2_r, empty2_r, start2_r;
  logic [PROD_W-1:0]    phi2_r, plo2_r;
  // Stage 3: scaled value.
  logic                 v3_r, ovf3_r, start3_r;
  logic [VALUE_W-1:0]   scaled3_r;

  logic [COORD_W-1:0]   mag;
  logic [PROD_W-1:0]    phi_nxt, plo_nxt;
  logic [SUM_W-1:0]     q;
  logic                 ovf_nxt;
  logic [VALUE_W-1:0]   scaled_nxt;

  // Encoder history.
  logic [VALUE_W-1:0]   prev_r [4];
  logic [1:0]           dim_r, dim_nxt, d;
  logic                 first_r, first_nxt, first;
  logic [DIMS_W-1:0]    width;
  logic [VALUE_W-1:0]   delta;
  logic                 commit;

  assign mag     = coord_fixed[COORD_W-1] ? (COORD_W'(0) - coord_fixed) : coord_fixed;
  assign phi_nxt = hi1_r * cfg_scale;
  assign plo_nxt = lo1_r * cfg_scale;

  always_comb begin
    q = {1'b0, phi2_r} + ((SUM_W'(plo2_r) + HALF_LSB) >> FRAC_BITS);
    if (empty2_r) begin
      ovf_nxt    = 1'b0;
      scaled_nxt = EMPTY_VALUE;
    end else if (neg2_r) begin
      ovf_nxt    = q > NEG_LIMIT;
      scaled_nxt = VALUE_W'(0) - q[VALUE_W-1:0];
    end else begin
      ovf_nxt    = q > POS_LIMIT;
      scaled_nxt = q[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    neg1_r    <= coord_fixed[COORD_W-1];
    empty1_r  <= is_empty;
    start1_r  <= starts_sequence;
    hi1_r     <= mag[COORD_W-1:FRAC_BITS];
    lo1_r     <= mag[FRAC_BITS-1:0];
    neg2_r    <= neg1_r;
    empty2_r  <= empty1_r;
    start2_r  <= start1_r;
    phi2_r    <= phi_nxt;
    plo2_r    <= plo_nxt;
    ovf3_r    <= ovf_nxt;
    start3_r  <= start2_r;
    scaled3_r <= scaled_nxt;
  end

  // Classify the stage 3 item and update history in the same cycle.
  always_comb begin
    width = cfg_dims;
    if (cfg_dims < DIMS_MIN) width = DIMS_MIN;
    if (cfg_dims > DIMS_MAX) width = DIMS_MAX;
    d      = start3_r ? 2'd0 : dim_r;
    first  = start3_r ? 1'b1 : first_r;
    delta  = scaled3_r - prev_r[d];
    commit = v3_r && !ovf3_r;

    if (ovf3_r) begin
      push_entry.kind  = KIND_ERROR;
      push_entry.value = '0;
    end else if (first) begin
      push_entry.kind  = KIND_ABS4;
      push_entry.value = scaled3_r;
    end else if (delta <= DELTA_POS || delta >= DELTA_NEG) begin
      push_entry.kind  = KIND_DELTA2;
      push_entry.value = delta;
    end else begin
      push_entry.kind  = KIND_ESC6;
      push_entry.value = delta;
    end

    if ({1'b0, d} + 3'd1 >= width) begin
      dim_nxt   = 2'd0;
      first_nxt = 1'b0;
    end else begin
      dim_nxt   = d + 2'd1;
      first_nxt = first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r   <= 2'd0;
      first_r <= 1'b1;
      for (int i = 0; i < 4; i++) prev_r[i] <= '0;
    end else if (commit) begin
      dim_r     <= dim_nxt;
      first_r   <= first_nxt;
      prev_r[d] <= scaled3_r;
    end
  end

  assign push     = v3_r;
  assign inflight = 2'({1'b0, v1_r} + {1'b0, v2_r} + {1'b0, v3_r});

endmodule

### hw/rtl/cde_fifo.sv
// ----------------------------------------------------------------------------
// Coordinate delta encoder queue
// Short FIFO of classified items between front and back end.
// ----------------------------------------------------------------------------
`include "coordinate_delta_encoder_defines.svh"

module cde_fifo #(
  parameter int DEPTH = cde_pkg::CDE_QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  cde_pkg::entry_t              push_entry,
  input  logic                         pop,
  output cde_pkg::entry_t              head,
  output logic                         not_empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import cde_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

  `CDE_ASSERT_IMPL(a_no_overrun, count_r == CNT_W'(DEPTH), !push, "push into full queue")
  `CDE_ASSERT_IMPL(a_no_underrun, pop, count_r != '0, "pop from empty queue")
  `CDE_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1,
                   "count did not follow push")

endmodule

### hw/rtl/cde_back.sv
// ----------------------------------------------------------------------------
// Coordinate delta encoder back end
// Serializes each classified item into bytes behind an output register.
// ----------------------------------------------------------------------------
`include "coordinate_delta_encoder_defines.svh"

module cde_back (
  input  logic             clk,
  input  logic             rst_n,
  input  cde_pkg::entry_t  head,
  input  logic             not_empty,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);
  import cde_pkg::*;

  logic               busy_r, busy_nxt;
  kind_t              kind_r, kind_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic               valid_r, valid_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               last_r, last_nxt;
  logic               err_r, err_nxt;

  logic               slot_free, emit, at_last;
  logic [7:0]         sel_byte;
  logic [2:0]         val_idx;

  always_comb begin
    val_idx = (kind_r == KIND_ESC6) ? idx_r - 3'd2 : idx_r;
    case (val_idx[1:0])
      2'd0:    sel_byte = val_r[7:0];
      2'd1:    sel_byte = val_r[15:8];
      2'd2:    sel_byte = val_r[23:16];
      2'd3:    sel_byte = val_r[31:24];
      default: sel_byte = val_r[7:0];
    endcase
    if (kind_r == KIND_ESC6 && idx_r == 3'd0) sel_byte = ESC_LO;
    if (kind_r == KIND_ESC6 && idx_r == 3'd1) sel_byte = ESC_HI;
    if (kind_r == KIND_ERROR) sel_byte = 8'h00;

    slot_free = !valid_r || out_tready;
    emit      = slot_free && busy_r;
    at_last   = (idx_r == last_index(kind_r));
    pop       = not_empty && (!busy_r || (emit && at_last));

    busy_nxt = busy_r;
    kind_nxt = kind_r;
    val_nxt  = val_r;
    idx_nxt  = idx_r;
    if (emit) idx_nxt = idx_r + 3'd1;
    if (emit && at_last) busy_nxt = 1'b0;
    if (pop) begin
      busy_nxt = 1'b1;
      kind_nxt = head.kind;
      val_nxt  = head.value;
      idx_nxt  = 3'd0;
    end

    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    err_nxt   = err_r;
    if (slot_free) begin
      valid_nxt = busy_r;
      byte_nxt  = sel_byte;
      last_nxt  = at_last;
      err_nxt   = (kind_r == KIND_ERROR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
    kind_r <= kind_nxt;
    val_r  <= val_nxt;
    idx_r  <= idx_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    err_r  <= err_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = err_r;

  `CDE_ASSERT_IMPL(a_err_single, valid_r && err_r, last_r && byte_r == 8'h00,
                   "error result must be a single zero byte")
  `CDE_ASSERT_IMPL(a_idx_range, busy_r, idx_r <= last_index(kind_r),
                   "byte index past end of item")

endmodule

### hw/rtl/coordinate_delta_encoder.sv
// ----------------------------------------------------------------------------
// Coordinate delta encoder
// Scales fixed-point coordinates to int32 and emits delta-coded bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one coordinate per transfer. in_tdata = coord_fixed (signed,
//           24 fraction bits); in_tuser = {starts_sequence, is_empty}.
//   out_* : one encoded byte per transfer, least significant first.
//           out_tlast marks the final byte of a coordinate, out_tuser flags
//           an int32 overflow (single zero byte, no history update).
//   cfg_* : register writes (index 0 coord_scale, 1 dims_per_vertex),
//           always accepted; write only while the block is idle.
// Path: with the queue empty, an input transfer reaches out_tvalid through
//   three scaling stages, the queue, the byte loader and the output register.
// Output: 2, 4 or 6 bytes per coordinate (1 for an overflow) on the byte-wide
//   output channel; the next coordinate is loaded as the last byte of the
//   previous one enters the output register. At most four coordinates sit
//   between the scaling stages and the queue.
// Reset clears history (all dimensions 0, first vertex pending) and
//   reloads scale 10000000 and 2 dimensions. When the receiver stalls,
//   the output byte holds and in_tready drops once four coordinates are
//   held in the scaling stages and the queue together.
module coordinate_delta_encoder #(
  parameter int QUEUE_DEPTH = cde_pkg::CDE_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cde_pkg::COORD_W-1:0]      in_tdata,   // [47:0] coord_fixed
  input  logic [1:0]                       in_tuser,   // [0] is_empty, [1] starts_sequence
  // Result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] out_byte
  output logic                             out_tlast,  // last_byte
  output logic                             out_tuser,  // [0] overflow_error
  // Configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cde_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cde_pkg::SCALE_W-1:0]      cfg_data
);
  import cde_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [SCALE_W-1:0] scale_r;
  logic [DIMS_W-1:0]  dims_r;

  logic               in_take;
  logic               push, pop, not_empty;
  entry_t             push_entry, head;
  logic [1:0]         inflight;
  logic [CNT_W-1:0]   count;
  logic [CNT_W:0]     used;

  // Configuration registers; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      dims_r  <= DIMS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COORD_SCALE:     scale_r <= cfg_data;
        REG_DIMS_PER_VERTEX: dims_r  <= cfg_data[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // Credit check: every accepted item must find a queue slot when it leaves the
  // scaling stages, so count items still in the scaling pipeline against the queue.
  assign used      = {1'b0, count} + (CNT_W + 1)'(inflight);
  assign in_tready = used < (CNT_W + 1)'(QUEUE_DEPTH);
  assign in_take   = in_tvalid && in_tready;

  cde_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_take         (in_take),
    .coord_fixed     (in_tdata),
    .is_empty        (in_tuser[0]),
    .starts_sequence (in_tuser[1]),
    .cfg_scale       (scale_r),
    .cfg_dims        (dims_r),
    .push            (push),
    .push_entry      (push_entry),
    .inflight        (inflight)
  );

  cde_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .count      (count)
  );

  cde_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .not_empty  (not_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### sim/coordinate_delta_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate delta encoder testbench
// Streams fixed-point coordinates through the encoder and checks every
// output byte against a cycle-free prediction of the byte stream.
// ----------------------------------------------------------------------------
module coordinate_delta_encoder_test;
  import cde_pkg::*;

  localparam int   SETTLE_CYCLES = 8;
  localparam int   TAIL_CYCLES   = 20;
  localparam int   STALL_LIMIT   = 2000;  // cycles without any transfer
  localparam int   PHASE_ITEMS   = 54;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  // One expected byte of the encoded stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       overflow;
  } enc_byte_t;

  // --------------------------------------------------------------------------
  // Byte stream predictor and checker. Keeps its own copy of the registers
  // and of the per-dimension history; each accepted coordinate queues the
  // bytes it must produce, each output transfer is matched against the
  // oldest queued byte.
  // --------------------------------------------------------------------------
  class delta_stream_checker;
    localparam int MAX_REPORTS = 40;

    logic [SCALE_W-1:0] scale;
    logic [DIMS_W-1:0]  dims;
    logic [31:0]        history [4];
    logic [1:0]         dim_idx;
    logic               first_vertex;
    enc_byte_t          pending_bytes [$];
    int                 errors;

    function new();
      scale = SCALE_RESET;
      dims  = DIMS_RESET;
      foreach (history[k]) history[k] = '0;
      dim_idx      = '0;
      first_vertex = 1'b1;
      errors       = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Append one expected byte behind the ones already waiting.
    function void queue_byte(enc_byte_t e);
      pending_bytes.insert(pending_bytes.size(), e);
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [SCALE_W-1:0] data);
      if (idx == REG_COORD_SCALE) scale = data;
      else if (idx == REG_DIMS_PER_VERTEX) dims = data[DIMS_W-1:0];
    endfunction

    // Multiply by the scale, round half away from zero; 0 on int32 overflow.
    function bit scale_coord(logic [COORD_W-1:0] raw, output logic [31:0] scaled);
      logic [COORD_W-1:0] mag;
      logic [63:0]        hi, lo, q;
      mag = raw[COORD_W-1] ? (~raw + 48'd1) : raw;
      hi  = {40'd0, mag[47:24]};
      lo  = {40'd0, mag[23:0]};
      q   = hi * scale + ((lo * scale + HALF_LSB) >> FRAC_BITS);
      if (raw[COORD_W-1]) begin
        if (q > 64'h8000_0000) return 1'b0;
        scaled = ~q[31:0] + 32'd1;
      end else begin
        if (q > 64'h7FFF_FFFF) return 1'b0;
        scaled = q[31:0];
      end
      return 1'b1;
    endfunction

    function void note_coord(logic [COORD_W-1:0] coord, logic empty, logic start);
      logic [31:0] value, delta;
      logic [7:0]  bytes [6];
      enc_byte_t   e;
      int          n, width, d;
      if (empty) begin
        value = EMPTY_VALUE;
      end else if (!scale_coord(coord, value)) begin
        // Overflow: one zero byte, history and sequence flag untouched
        e = '{data_byte: 8'h00, last_byte: 1'b1, overflow: 1'b1};
        queue_byte(e);
        return;
      end
      if (start) begin
        dim_idx      = '0;
        first_vertex = 1'b1;
      end
      width = (dims < DIMS_MIN) ? int'(DIMS_MIN) : (dims > DIMS_MAX) ? int'(DIMS_MAX) : int'(dims);
      d = int'(dim_idx);
      if (first_vertex) begin
        for (int i = 0; i < 4; i++) bytes[i] = value[8*i +: 8];
        n = 4;
      end else begin
        delta = value - history[d];
        if (delta <= DELTA_POS || delta >= DELTA_NEG) begin
          bytes[0] = delta[7:0];
          bytes[1] = delta[15:8];
          n = 2;
        end else begin
          bytes[0] = ESC_LO;
          bytes[1] = ESC_HI;
          for (int i = 0; i < 4; i++) bytes[2+i] = delta[8*i +: 8];
          n = 6;
        end
      end
      for (int i = 0; i < n; i++) begin
        e = '{data_byte: bytes[i], last_byte: (i == n - 1), overflow: 1'b0};
        queue_byte(e);
      end
      history[d] = value;
      if (d + 1 >= width) begin
        dim_idx      = '0;
        first_vertex = 1'b0;
      end else begin
        dim_idx = 2'(d + 1);
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic ovf);
      enc_byte_t e;
      if (pending_bytes.size() == 0) begin
        flag($sformatf("%0t: unexpected byte 0x%02h (last %0b, overflow %0b)",
                       $time, data, last, ovf));
        return;
      end
      e = pending_bytes.pop_front();
      if (data !== e.data_byte)
        flag($sformatf("%0t: out_byte mismatch, expected 0x%02h, actual 0x%02h",
                       $time, e.data_byte, data));
      if (last !== e.last_byte)
        flag($sformatf("%0t: last_byte mismatch, expected %0b, actual %0b",
                       $time, e.last_byte, last));
      if (ovf !== e.overflow)
        flag($sformatf("%0t: overflow_error mismatch, expected %0b, actual %0b",
                       $time, e.overflow, ovf));
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    function void flush_leftover();
      if (pending_bytes.size() != 0)
        flag($sformatf("%0t: %0d expected bytes never arrived", $time, pending_bytes.size()));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block instance
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [COORD_W-1:0]     in_tdata;    // [47:0] coord_fixed
  logic [1:0]             in_tuser;    // [0] is_empty, [1] starts_sequence
  logic                   out_tvalid;
  logic                   out_tready;
  logic [7:0]             out_tdata;   // [7:0] out_byte
  logic                   out_tlast;
  logic                   out_tuser;   // [0] overflow_error
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [SCALE_W-1:0]     cfg_data;

  delta_stream_checker sb;
  longint cur_scale;     // stimulus copy of the scale, shapes coordinate steps
  bit     quiet_tail;    // no idling on either side once set
  bit     moved;
  int     idle_cycles;

  coordinate_delta_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample every channel at the rising edge, feed the checker and
  // run the watchdog on cycles without any transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        sb.note_coord(in_tdata, in_tuser[0], in_tuser[1]);
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        sb.check_byte(out_tdata, out_tlast, out_tuser);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: alternate ready runs with stall bursts; hold ready high in the
  // quiet tail. Every change lands on a falling edge.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int burst;
    out_tready = 1'b0;
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_tready = 1'b0;
        burst = $urandom_range(1, 12);
      end else begin
        out_tready = 1'b1;
        burst = $urandom_range(1, 24);
      end
      repeat (burst) @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks; each starts and ends on a falling edge.
  // --------------------------------------------------------------------------

  // Present one coordinate, hold it until the transfer, then maybe idle.
  task automatic send_coord(input logic [COORD_W-1:0] coord, input bit empty, input bit start);
    in_tdata  = coord;
    in_tuser  = {start, empty};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every predicted byte has come out.
  task automatic wait_idle(input int settle);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SCALE_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  function automatic longint rand_signed(input longint lim);
    longint unsigned raw;
    raw = {$urandom, $urandom};
    return longint'(raw % (2 * lim + 1)) - lim;
  endfunction

  // Coordinate step that moves the scaled value by roughly the target.
  function automatic longint coord_step(input longint target);
    if (cur_scale == 0) return rand_signed(longint'(1) <<< 20);
    return (target <<< FRAC_BITS) / cur_scale;
  endfunction

  // Coordinate magnitude that keeps the scaled value near +-2^30.
  function automatic longint coord_span();
    longint lim;
    if (cur_scale == 0) return longint'(1) <<< 40;
    lim = (longint'(1) <<< 54) / cur_scale;
    if (lim > (longint'(1) <<< 46)) lim = longint'(1) <<< 46;
    return lim;
  endfunction

  function automatic logic [COORD_W-1:0] whole_units(input longint v);
    return COORD_W'(v <<< FRAC_BITS);
  endfunction

  // At scale 256 one scaled unit is 2^16 coordinate steps.
  function automatic logic [COORD_W-1:0] units_256(input longint v);
    return COORD_W'(v <<< 16);
  endfunction

  // --------------------------------------------------------------------------
  // Directed part: reset settings, overflow both ways, empty value, delta
  // limits and escape, rounding, start in mid-vertex, zero scale and a
  // vertex width shrinking under a vertex in progress.
  // --------------------------------------------------------------------------
  task automatic run_directed();
    localparam logic [COORD_W-1:0] HALF_UNIT = 48'h8000;
    // Reset settings: scale 10000000, two dimensions
    send_coord(whole_units(0), 0, 1);
    send_coord(whole_units(1), 0, 0);
    send_coord(48'h7FFF_FFFF_FFFF, 0, 1);   // overflow, start flag ignored
    send_coord(48'h8000_0000_0000, 0, 0);   // overflow on the negative side
    send_coord(whole_units(-3), 1, 0);      // empty value, escaped delta
    send_coord(whole_units(-1), 0, 0);

    wait_idle(SETTLE_CYCLES);
    write_reg(REG_COORD_SCALE, 31'd256);
    send_coord(units_256(100), 0, 1);
    send_coord(units_256(-100), 0, 0);
    send_coord(units_256(32867), 0, 0);     // delta +32767, short
    send_coord(units_256(-32867), 0, 0);    // delta -32767, short
    send_coord(units_256(65635), 0, 0);     // delta +32768, escaped
    send_coord(units_256(-65635), 0, 0);    // delta equal to the escape code
    send_coord(units_256(200) + HALF_UNIT, 0, 0);      // rounds up to 201
    send_coord(-(units_256(50) + HALF_UNIT), 0, 0);    // rounds down to -51
    send_coord(units_256(2147483647), 0, 0);           // int32 max, fits
    send_coord(48'h7FFF_FFFF_FFFF, 0, 0);              // rounds to 2^31, overflow
    send_coord(48'h8000_0000_0000, 0, 0);              // int32 min, fits
    send_coord(units_256(5), 0, 0);
    send_coord(units_256(7), 0, 1);                    // new sequence in mid-vertex

    // Widen to four, zero scale, then shrink under a vertex in progress
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_DIMS_PER_VERTEX, 31'd4);
    write_reg(REG_COORD_SCALE, 31'd0);
    send_coord(whole_units(123), 0, 0);
    send_coord(whole_units(-5), 1, 0);
    send_coord(48'h5555_AAAA_5555, 0, 0);
    send_coord(48'hAAAA_5555_AAAA, 0, 0);
    send_coord(whole_units(9), 0, 0);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_DIMS_PER_VERTEX, 31'd2);  // dimension 2 now ends the vertex
    send_coord(whole_units(1), 0, 0);
  endtask

  // --------------------------------------------------------------------------
  // Random phase: mostly well-formed sequences of whole vertices walking in
  // small steps, with large jumps, near-limit deltas and empty values; the
  // rest is raw noise and overflowing magnitudes.
  // --------------------------------------------------------------------------
  task automatic run_phase(input logic [SCALE_W-1:0] scale, input logic [DIMS_W-1:0] dims,
                           input int count, input int pause_at);
    longint             cursor [4];
    longint             lim, step;
    int                 width, lane, seq_left, pick, near_limit;
    logic [SCALE_W-1:0] dims_word;
    logic [COORD_W-1:0] coord;
    bit                 empty, start;
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_COORD_SCALE, scale);
    dims_word      = SCALE_W'($urandom);
    dims_word[2:0] = dims;                  // upper bits are don't-care
    write_reg(REG_DIMS_PER_VERTEX, dims_word);
    cur_scale = longint'(scale);
    width     = (dims < DIMS_MIN) ? 2 : (dims > DIMS_MAX) ? 4 : int'(dims);
    lim       = coord_span();
    seq_left  = 0;
    lane      = 0;
    step      = 0;
    foreach (cursor[k]) cursor[k] = 0;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_idle(0);
      pick  = $urandom_range(0, 99);
      empty = 1'b0;
      start = 1'b0;
      if (pick < 6) begin
        coord = COORD_W'({$urandom, $urandom});
        empty = $urandom_range(0, 1);
        start = $urandom_range(0, 1);
      end else if (pick < 9) begin
        coord = {($urandom_range(0, 1) ? 2'b10 : 2'b01), 46'({$urandom, $urandom})};
      end else begin
        if (seq_left == 0) begin
          start    = 1'b1;
          seq_left = width * $urandom_range(1, 5);
          lane     = 0;
          foreach (cursor[k]) cursor[k] = rand_signed(lim);
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          empty = 1'b1;
        end else begin
          if (pick < 80) begin
            step = coord_step(rand_signed(30000));
          end else if (pick < 88) begin
            near_limit = 32767 + int'($urandom_range(0, 2));
            if ($urandom_range(0, 1) == 1) near_limit = -near_limit;
            step = coord_step(near_limit);
          end else begin
            step = coord_step(rand_signed(longint'(1) <<< 28));
          end
          cursor[lane] += step;
        end
        coord    = COORD_W'(cursor[lane]);
        lane     = (lane + 1) % width;
        seq_left--;
      end
      send_coord(coord, empty, start);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb          = new();
    cur_scale   = 10000000;
    quiet_tail  = 1'b0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    // Walk through scales and vertex widths, extremes and out-of-range widths
    run_phase(31'd10000000, 3'd2, PHASE_ITEMS, -1);
    run_phase(31'd10000000, 3'd3, PHASE_ITEMS, -1);
    run_phase(31'h7FFF_FFFF, 3'd4, PHASE_ITEMS, PHASE_ITEMS / 2);
    run_phase(31'd1, 3'd0, PHASE_ITEMS, -1);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_UNMAPPED, SCALE_W'($urandom));  // unmapped index changes nothing
    run_phase(SCALE_W'($urandom_range(2, 32'h7FFF_FFFE)), 3'd5, PHASE_ITEMS, -1);
    run_phase(31'd0, 3'd1, PHASE_ITEMS / 2, -1);
    run_phase(31'd16777216, 3'd7, PHASE_ITEMS, -1);

    // Closing stretch runs at full rate on both sides
    quiet_tail = 1'b1;
    run_phase(31'd10000000, 3'd2, PHASE_ITEMS, -1);

    wait_idle(TAIL_CYCLES);
    sb.flush_leftover();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
